@@ src/cpsr_pkg.sv @@
// Shared types and constants for the controller port serial reader.
package cpsr_pkg;

    localparam int PAD_W        = 16;
    localparam int IO_W         = 8;
    localparam int BITS_PER_PAD_DEFAULT = 16;

    // I/O port bits that pick pads A/B (1) or C/D (0) on each port
    localparam int IO_SEL_BIT_PORT0 = 6;
    localparam int IO_SEL_BIT_PORT1 = 7;

    // register indexes on the configuration port
    localparam logic CFG_PORT0_DEVICE = 1'b0;
    localparam logic CFG_PORT1_DEVICE = 1'b1;

    // device codes; code 3 reads as no device
    typedef enum logic [1:0] {
        DEV_NONE     = 2'd0,
        DEV_JOYPAD   = 2'd1,
        DEV_MULTITAP = 2'd2
    } dev_t;

    // result codes that do not come from button bits
    localparam logic [1:0] RES_ZERO        = 2'd0;
    localparam logic [1:0] RES_JOY_DONE    = 2'd1;
    localparam logic [1:0] RES_TAP_LATCHED = 2'd2;
    localparam logic [1:0] RES_TAP_DONE    = 2'd3;

    typedef struct packed {
        logic              mode;
        logic              port;
        logic              latch_level;
        logic [IO_W-1:0]   io_port_value;
        logic [PAD_W-1:0]  pad_a_buttons;
        logic [PAD_W-1:0]  pad_b_buttons;
        logic [PAD_W-1:0]  pad_c_buttons;
        logic [PAD_W-1:0]  pad_d_buttons;
    } item_t;

endpackage

@@ src/cpsr_in_stage.sv @@
// Input register stage of the controller port serial reader.
module cpsr_in_stage
    import cpsr_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  in_valid,
    output logic  in_ready,
    input  item_t in_item,
    input  logic  advance,
    output logic  stage_valid,
    output item_t stage_item
);

    logic  valid_reg;
    logic  valid_next;
    item_t item_reg;

    // take a new item when empty or when the held one moves on this cycle
    assign in_ready = !valid_reg || advance;

    always_comb
    begin
        valid_next = valid_reg;
        if (in_ready)
        begin
            valid_next = in_valid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            item_reg <= in_item;
        end
    end

    assign stage_valid = valid_reg;
    assign stage_item  = item_reg;

endmodule

@@ src/cpsr_core.sv @@
// Device registers, bit counters and read logic for both controller ports.
module cpsr_core
    import cpsr_pkg::*;
#(
    parameter int BITS_PER_PAD = BITS_PER_PAD_DEFAULT
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [1:0]  cfg_data,
    input  logic        fire,
    input  item_t       item,
    output logic [1:0]  result
);

    localparam int CNT_W = $clog2(BITS_PER_PAD + 1);
    localparam logic [CNT_W-1:0] CNT_LIMIT = CNT_W'(BITS_PER_PAD);
    localparam logic [CNT_W-1:0] CNT_ONE   = CNT_W'(1);

    logic [1:0]       dev0_reg, dev0_next;
    logic [1:0]       dev1_reg, dev1_next;
    logic [CNT_W-1:0] first_reg  [2];
    logic [CNT_W-1:0] first_next [2];
    logic [CNT_W-1:0] second_reg  [2];
    logic [CNT_W-1:0] second_next [2];

    logic [1:0]       dev;
    logic             sel_ab;
    logic [CNT_W-1:0] idx;
    logic [CNT_W+3:0] idx_wide;
    logic [3:0]       bit_idx;
    logic [PAD_W-1:0] word0;
    logic [PAD_W-1:0] word1;

    assign dev    = item.port ? dev1_reg : dev0_reg;
    assign sel_ab = item.port ? item.io_port_value[IO_SEL_BIT_PORT1]
                              : item.io_port_value[IO_SEL_BIT_PORT0];

    // joypad always runs on the first counter
    assign idx = (dev == DEV_MULTITAP && !sel_ab) ? second_reg[item.port]
                                                   : first_reg[item.port];
    assign idx_wide = {4'd0, idx};
    assign bit_idx  = idx_wide[3:0];
    assign word0    = (dev == DEV_MULTITAP && !sel_ab) ? item.pad_c_buttons
                                                        : item.pad_a_buttons;
    assign word1    = sel_ab ? item.pad_b_buttons : item.pad_d_buttons;

    always_comb
    begin
        dev0_next   = dev0_reg;
        dev1_next   = dev1_reg;
        first_next  = first_reg;
        second_next = second_reg;
        result      = RES_ZERO;

        if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_PORT0_DEVICE:
                begin
                    dev0_next = cfg_data;
                end
                CFG_PORT1_DEVICE:
                begin
                    dev1_next = cfg_data;
                end
            endcase
            first_next[cfg_index]  = '0;
            second_next[cfg_index] = '0;
        end
        else if (fire)
        begin
            if (item.mode)
            begin
                // poll strobe: clear every counter
                first_next[0]  = '0;
                first_next[1]  = '0;
                second_next[0] = '0;
                second_next[1] = '0;
            end
            else
            begin
                unique case (dev)
                    DEV_JOYPAD:
                    begin
                        if (idx >= CNT_LIMIT)
                        begin
                            result = RES_JOY_DONE;
                        end
                        else
                        begin
                            result = {1'b0, word0[bit_idx]};
                            first_next[item.port] = idx + CNT_ONE;
                        end
                    end
                    DEV_MULTITAP:
                    begin
                        if (item.latch_level)
                        begin
                            result = RES_TAP_LATCHED;
                        end
                        else if (idx >= CNT_LIMIT)
                        begin
                            result = RES_TAP_DONE;
                        end
                        else
                        begin
                            result = {word1[bit_idx], word0[bit_idx]};
                            if (sel_ab)
                            begin
                                first_next[item.port] = idx + CNT_ONE;
                            end
                            else
                            begin
                                second_next[item.port] = idx + CNT_ONE;
                            end
                        end
                    end
                    default:
                    begin
                        result = RES_ZERO;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dev0_reg      <= DEV_NONE;
            dev1_reg      <= DEV_NONE;
            first_reg[0]  <= '0;
            first_reg[1]  <= '0;
            second_reg[0] <= '0;
            second_reg[1] <= '0;
        end
        else
        begin
            dev0_reg   <= dev0_next;
            dev1_reg   <= dev1_next;
            first_reg  <= first_next;
            second_reg <= second_next;
        end
    end

endmodule

@@ src/controller_port_serial_reader.sv @@
// Top level: two serial controller ports with joypad or multitap devices.
//
// Input channel (in_valid/in_ready) carries one item per read access:
// mode 1 is a poll strobe that clears all bit counters and answers 0,
// mode 0 reads one bit position of the selected port, with the button
// words of the four pads and the latch and I/O port levels alongside.
// Output channel (out_valid/out_ready) returns one read_data per item,
// in order.
// Configuration: cfg_we writes cfg_data into the device register picked
// by cfg_index (0 port 0, 1 port 1); each write clears that port's
// counters. Write only while no item is in flight.
// An accepted item waits in the input register while the read logic works
// on it, and moves into the result register, which drives out_valid, when
// there is room there.
// Throughput is one item per cycle while out_ready is high; the counter
// update is a read-modify-write done as each item advances, so back-to-back items see each other's counts.
// When out_ready is low the result register holds, the input register
// fills behind it, and in_ready drops once both are full.
// Reset clears both stages, sets both devices to none and zeroes all
// counters.
module controller_port_serial_reader
    import cpsr_pkg::*;
#(
    parameter int BITS_PER_PAD = BITS_PER_PAD_DEFAULT
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_we,
    input  logic              cfg_index,
    input  logic [1:0]        cfg_data,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic              mode,
    input  logic              port,
    input  logic              latch_level,
    input  logic [IO_W-1:0]   io_port_value,
    input  logic [PAD_W-1:0]  pad_a_buttons,
    input  logic [PAD_W-1:0]  pad_b_buttons,
    input  logic [PAD_W-1:0]  pad_c_buttons,
    input  logic [PAD_W-1:0]  pad_d_buttons,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [1:0]        read_data
);

    item_t      in_item;
    item_t      stage_item;
    logic       stage_valid;
    logic       advance;
    logic [1:0] result;

    logic       out_valid_reg, out_valid_next;
    logic [1:0] read_data_reg;

    assign in_item = '{
        mode:          mode,
        port:          port,
        latch_level:   latch_level,
        io_port_value: io_port_value,
        pad_a_buttons: pad_a_buttons,
        pad_b_buttons: pad_b_buttons,
        pad_c_buttons: pad_c_buttons,
        pad_d_buttons: pad_d_buttons
    };

    // move the held item into the result register when there is room
    assign advance = stage_valid && (!out_valid_reg || out_ready);

    cpsr_in_stage u_in_stage (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .in_item     (in_item),
        .advance     (advance),
        .stage_valid (stage_valid),
        .stage_item  (stage_item)
    );

    cpsr_core #(
        .BITS_PER_PAD (BITS_PER_PAD)
    ) u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .fire      (advance),
        .item      (stage_item),
        .result    (result)
    );

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (advance)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            read_data_reg <= result;
        end
    end

    assign out_valid = out_valid_reg;
    assign read_data = read_data_reg;

endmodule
